// ----- sv/bvm_pkg.sv -----
// shared types and constants of the battery voltage monitor
package bvm_pkg;

    // field widths
    localparam int ADC_BITS      = 12;
    localparam int CHAN_BITS     = 2;
    localparam int TIME_BITS     = 32;
    localparam int MV_BITS       = 16;
    localparam int CELL_BITS     = 3;
    localparam int GAIN_BITS     = 24;
    localparam int GAIN_FRAC     = 16;
    localparam int DROP_BITS     = 12;
    localparam int CELL_MV_BITS  = 13;
    localparam int HYST_BITS     = 12;
    localparam int INTERVAL_BITS = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // fixed limits
    localparam logic [MV_BITS-1:0]   MV_MAX       = 16'hFFFF;
    localparam logic [MV_BITS-1:0]   MIN_WIRED_MV = 16'd500;
    localparam int                   MAX_CELLS    = 6;

    // register values after reset
    localparam logic [GAIN_BITS-1:0]     RST_ADC_GAIN  = 24'd580906;
    localparam logic [DROP_BITS-1:0]     RST_DROP_MV   = 12'd0;
    localparam logic [CELL_MV_BITS-1:0]  RST_CHARGED   = 13'd4200;
    localparam logic [CELL_MV_BITS-1:0]  RST_CUTOFF    = 13'd3300;
    localparam logic [HYST_BITS-1:0]     RST_HYST      = 12'd100;
    localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL  = 16'd100;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ADC_GAIN    = 3'd0,
        CFG_DIODE_DROP  = 3'd1,
        CFG_CHARGED     = 3'd2,
        CFG_CUTOFF      = 3'd3,
        CFG_HYSTERESIS  = 3'd4,
        CFG_INTERVAL    = 3'd5
    } t_cfg_idx;

    // request kinds
    typedef enum logic {
        REQ_INIT   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef struct packed {
        t_req                  req_type;
        logic [CHAN_BITS-1:0]  channel;
        logic [ADC_BITS-1:0]   adc_count;
        logic [TIME_BITS-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_BITS-1:0]  out_channel;
        logic [MV_BITS-1:0]    avg_mv;
        logic [MV_BITS-1:0]    init_mv;
        logic [CELL_BITS-1:0]  cell_count;
        logic                  low_flag;
        logic                  low_changed;
        logic                  chan_disabled;
        logic                  sample_taken;
    } t_out_item;

endpackage

// ----- sv/bvm_if.sv -----
// valid/ready channel interfaces of the battery voltage monitor

interface bvm_in_if;
    logic                valid;
    logic                ready;
    bvm_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bvm_out_if;
    logic                valid;
    logic                ready;
    bvm_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/battery_voltage_monitor_top.sv -----
// top level of the battery voltage monitor
//
// usage:
// - i_in carries one transaction per adc reading: init or periodic sample of one
//   channel; o_res returns exactly one result transaction per input, in order
// - registers are written through i_cfg_wr_en / i_cfg_index / i_cfg_data while
//   the block is idle; they are shared by all channels
// - a result passes through the stage 1 and stage 2 registers and is then
//   offered from the result queue
// - throughput: one transaction per cycle while the queue has room, set by the
//   single read-modify-write of the channel record and window memories with
//   one-deep forwarding; per-channel state lives in two memories read at acceptance
//   and written back from stage 1; small per-channel control bits sit in flops
// - at reset every channel reads as not initialised with zero voltages; the
//   window memory needs no clearing since entries are tracked by a fill count
// - a four-entry result queue follows the pipeline; i_in.ready drops only when
//   the queue plus items in flight would exceed it, so a stalled receiver
//   blocks input after at most four further transactions
module battery_voltage_monitor_top #(
    parameter int CHANNELS     = 4,
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [bvm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bvm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    bvm_in_if.sink                              i_in,
    bvm_out_if.source                           o_res
);

    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW   = $clog2(WINDOW_DEPTH);
    localparam int FW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SW   = bvm_pkg::MV_BITS + DW;
    localparam int MW   = SW + 2;
    localparam int RSH  = SW + DW;
    localparam int PW   = bvm_pkg::ADC_BITS + bvm_pkg::GAIN_BITS;
    localparam int MIW  = PW - bvm_pkg::GAIN_FRAC;
    localparam int QD   = 4;
    localparam int QAW  = 2;
    localparam int QCW  = 3;
    localparam logic [63:0]   RECIP_FULL =
        ((64'd1 << RSH) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH);
    localparam logic [MW-1:0] RECIP  = RECIP_FULL[MW-1:0];
    localparam logic [DW-1:0] D_LAST = DW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] D_FULL = FW'(WINDOW_DEPTH);

    typedef struct packed {
        logic [SW-1:0]                       sum;
        logic [bvm_pkg::MV_BITS-1:0]         start;
        logic [bvm_pkg::CELL_BITS-1:0]       cells;
        logic [bvm_pkg::TIME_BITS-1:0]       last_ms;
    } t_rec;

    // configuration registers
    logic [bvm_pkg::GAIN_BITS-1:0]      r_adc_gain;
    logic [bvm_pkg::DROP_BITS-1:0]      r_diode_drop;
    logic [bvm_pkg::CELL_MV_BITS-1:0]   r_charged;
    logic [bvm_pkg::CELL_MV_BITS-1:0]   r_cutoff;
    logic [bvm_pkg::HYST_BITS-1:0]      r_hyst;
    logic [bvm_pkg::INTERVAL_BITS-1:0]  r_interval;

    // per-channel control flops
    logic [DW-1:0]          r_ptr      [CHANNELS];
    logic [FW-1:0]          r_fill     [CHANNELS];
    logic                   r_ready    [CHANNELS];
    logic                   r_off      [CHANNELS];
    logic                   r_rec_vld  [CHANNELS];
    logic [bvm_pkg::MV_BITS-1:0] r_avg [CHANNELS];
    logic                   r_low      [CHANNELS];

    // memories
    logic [bvm_pkg::MV_BITS-1:0] r_win_mem [CHANNELS * (2 ** DW)];
    t_rec                        r_rec_mem [CHANNELS];
    logic [bvm_pkg::MV_BITS-1:0] r_win_rdata;
    t_rec                        r_rec_rdata;

    // forwarding of the last record write
    logic                   r_fwd_vld;
    logic [CHW-1:0]         r_fwd_idx;
    t_rec                   r_fwd_rec;

    // input side
    bvm_pkg::t_in_item      in_item;
    logic                   accept;
    logic                   in_ok;
    logic [CHW-1:0]         in_idx;
    logic                   s1_hit;
    logic [DW-1:0]          s0_ptr;
    logic [FW-1:0]          s0_fill;
    logic                   s0_ready;
    logic                   s0_off;

    // stage 1 registers
    logic                   r_s1_vld;
    bvm_pkg::t_req          r_s1_req;
    logic [CHW-1:0]         r_s1_idx;
    logic [bvm_pkg::CHAN_BITS-1:0] r_s1_chan;
    logic                   r_s1_inrange;
    logic [bvm_pkg::TIME_BITS-1:0] r_s1_now;
    logic [PW-1:0]          r_s1_prod;
    logic [DW-1:0]          r_s1_ptr;
    logic [FW-1:0]          r_s1_fill;
    logic                   r_s1_ready;
    logic                   r_s1_off;

    // stage 1 logic
    logic [MIW:0]                  mv_sum;
    logic [bvm_pkg::MV_BITS-1:0]   mv1;
    t_rec                          rec_cur;
    logic [bvm_pkg::MV_BITS-1:0]   old_mv;
    logic                          interval_ok;
    logic                          wired;
    logic [bvm_pkg::CELL_BITS-1:0] det_cells;
    t_rec                          n_rec;
    logic [DW-1:0]                 n_ptr;
    logic [FW-1:0]                 n_fill;
    logic                          n_ready;
    logic                          n_off;
    logic                          s1_taken;
    logic                          win_we;
    logic                          rec_we;
    logic [bvm_pkg::MV_BITS-1:0]   s1_trip;
    logic [bvm_pkg::MV_BITS:0]     s1_rearm;

    // stage 2 registers
    logic                   r_s2_vld;
    bvm_pkg::t_req          r_s2_req;
    logic [CHW-1:0]         r_s2_idx;
    logic [bvm_pkg::CHAN_BITS-1:0] r_s2_chan;
    logic                   r_s2_inrange;
    logic                   r_s2_taken;
    logic [SW-1:0]          r_s2_sum;
    logic [bvm_pkg::MV_BITS-1:0]   r_s2_start;
    logic [bvm_pkg::CELL_BITS-1:0] r_s2_cells;
    logic                   r_s2_off;
    logic [bvm_pkg::MV_BITS-1:0]   r_s2_trip;
    logic [bvm_pkg::MV_BITS:0]     r_s2_rearm;

    // stage 2 logic
    logic [SW+MW-1:0]              avg_prod;
    logic [bvm_pkg::MV_BITS-1:0]   avg_div;
    logic [bvm_pkg::MV_BITS-1:0]   avg_cur;
    logic                          low_cur;
    logic [bvm_pkg::MV_BITS-1:0]   n_avg;
    logic                          n_low;
    bvm_pkg::t_out_item            s2_res;

    // result queue
    bvm_pkg::t_out_item     r_q [QD];
    logic [QAW-1:0]         r_q_wp;
    logic [QAW-1:0]         r_q_rp;
    logic [QCW-1:0]         r_q_cnt;
    logic                   q_pop;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_gain   <= bvm_pkg::RST_ADC_GAIN;
            r_diode_drop <= bvm_pkg::RST_DROP_MV;
            r_charged    <= bvm_pkg::RST_CHARGED;
            r_cutoff     <= bvm_pkg::RST_CUTOFF;
            r_hyst       <= bvm_pkg::RST_HYST;
            r_interval   <= bvm_pkg::RST_INTERVAL;
        end else if (i_cfg_wr_en) begin
            unique case (bvm_pkg::t_cfg_idx'(i_cfg_index))
                bvm_pkg::CFG_ADC_GAIN:   r_adc_gain   <= i_cfg_data[bvm_pkg::GAIN_BITS-1:0];
                bvm_pkg::CFG_DIODE_DROP: r_diode_drop <= i_cfg_data[bvm_pkg::DROP_BITS-1:0];
                bvm_pkg::CFG_CHARGED:    r_charged    <= i_cfg_data[bvm_pkg::CELL_MV_BITS-1:0];
                bvm_pkg::CFG_CUTOFF:     r_cutoff     <= i_cfg_data[bvm_pkg::CELL_MV_BITS-1:0];
                bvm_pkg::CFG_HYSTERESIS: r_hyst       <= i_cfg_data[bvm_pkg::HYST_BITS-1:0];
                bvm_pkg::CFG_INTERVAL:   r_interval   <= i_cfg_data[bvm_pkg::INTERVAL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input acceptance, limited by queue room
    assign in_item  = i_in.data;
    assign i_in.ready = (QCW'(r_q_cnt) + QCW'(r_s1_vld) + QCW'(r_s2_vld)) < QCW'(QD);
    assign accept   = i_in.valid && i_in.ready;
    assign in_ok    = int'(in_item.channel) < CHANNELS;
    assign in_idx   = CHW'(in_item.channel);

    // control bits of the incoming channel, forwarded from stage 1
    always_comb begin
        s1_hit = r_s1_vld && r_s1_inrange && (r_s1_idx == in_idx);
        if (s1_hit) begin
            s0_ptr   = n_ptr;
            s0_fill  = n_fill;
            s0_ready = n_ready;
            s0_off   = n_off;
        end else if (in_ok) begin
            s0_ptr   = r_ptr[in_idx];
            s0_fill  = r_fill[in_idx];
            s0_ready = r_ready[in_idx];
            s0_off   = r_off[in_idx];
        end else begin
            s0_ptr   = '0;
            s0_fill  = '0;
            s0_ready = 1'b0;
            s0_off   = 1'b0;
        end
    end

    // memory ports: read on acceptance, write back from stage 1
    always_ff @(posedge i_clk) begin
        if (accept && in_ok) begin
            r_win_rdata <= r_win_mem[{in_idx, s0_ptr}];
            r_rec_rdata <= r_rec_mem[in_idx];
        end
        if (win_we) begin
            r_win_mem[{r_s1_idx, r_s1_ptr}] <= mv1;
        end
        if (rec_we) begin
            r_rec_mem[r_s1_idx] <= n_rec;
        end
    end

    // stage 1 registers, gain product taken here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        if (accept) begin
            r_s1_req     <= in_item.req_type;
            r_s1_idx     <= in_idx;
            r_s1_chan    <= in_item.channel;
            r_s1_inrange <= in_ok;
            r_s1_now     <= in_item.now_ms;
            r_s1_prod    <= PW'(in_item.adc_count) * PW'(r_adc_gain);
            r_s1_ptr     <= s0_ptr;
            r_s1_fill    <= s0_fill;
            r_s1_ready   <= s0_ready;
            r_s1_off     <= s0_off;
        end
    end

    // millivolts with diode drop, saturated
    assign mv_sum = (MIW+1)'(r_s1_prod[PW-1:bvm_pkg::GAIN_FRAC]) + (MIW+1)'(r_diode_drop);
    assign mv1    = (mv_sum > (MIW+1)'(bvm_pkg::MV_MAX)) ? bvm_pkg::MV_MAX
                                                         : mv_sum[bvm_pkg::MV_BITS-1:0];

    // channel record with forwarding of the write at the previous edge
    always_comb begin
        if (r_fwd_vld && (r_fwd_idx == r_s1_idx)) begin
            rec_cur = r_fwd_rec;
        end else if (r_s1_inrange && r_rec_vld[r_s1_idx]) begin
            rec_cur = r_rec_rdata;
        end else begin
            rec_cur = '0;
        end
    end

    // oldest window entry: unwritten since init means the seed value
    assign old_mv      = (FW'(r_s1_ptr) < r_s1_fill) ? r_win_rdata : rec_cur.start;
    assign interval_ok = (r_s1_now - rec_cur.last_ms) >= bvm_pkg::TIME_BITS'(r_interval);
    assign wired       = mv1 >= bvm_pkg::MIN_WIRED_MV;

    // cell count: thresholds rise with n, so count the ones passed
    always_comb begin
        det_cells = 3'd1;
        for (int k = 1; k < bvm_pkg::MAX_CELLS; k++) begin
            if ({1'b0, mv1, 1'b0} > 18'(r_charged) * 18'(2 * k + 1)) begin
                det_cells = det_cells + 3'd1;
            end
        end
    end

    // stage 1 state update
    always_comb begin
        n_rec    = rec_cur;
        n_ptr    = r_s1_ptr;
        n_fill   = r_s1_fill;
        n_ready  = r_s1_ready;
        n_off    = r_s1_off;
        s1_taken = 1'b0;
        win_we   = 1'b0;
        if (r_s1_vld && r_s1_inrange) begin
            if (r_s1_req == bvm_pkg::REQ_INIT) begin
                if (!wired) begin
                    n_off       = 1'b1;
                    n_ready     = 1'b0;
                    n_rec.cells = '0;
                end else begin
                    n_rec.sum     = SW'(mv1) * SW'(WINDOW_DEPTH);
                    n_rec.start   = mv1;
                    n_rec.cells   = det_cells;
                    n_rec.last_ms = r_s1_now;
                    n_ptr         = '0;
                    n_fill        = '0;
                    n_ready       = 1'b1;
                    n_off         = 1'b0;
                    s1_taken      = 1'b1;
                end
            end else if (r_s1_ready && !r_s1_off && interval_ok) begin
                n_rec.sum     = rec_cur.sum - SW'(old_mv) + SW'(mv1);
                n_rec.last_ms = r_s1_now;
                n_ptr         = (r_s1_ptr == D_LAST) ? '0 : r_s1_ptr + DW'(1);
                n_fill        = (r_s1_fill == D_FULL) ? r_s1_fill : r_s1_fill + FW'(1);
                win_we        = 1'b1;
                s1_taken      = 1'b1;
            end
        end
    end

    assign rec_we   = r_s1_vld && r_s1_inrange;
    assign s1_trip  = bvm_pkg::MV_BITS'(r_cutoff) * bvm_pkg::MV_BITS'(n_rec.cells);
    assign s1_rearm = ((bvm_pkg::MV_BITS+1)'(r_cutoff) + (bvm_pkg::MV_BITS+1)'(r_hyst))
                      * (bvm_pkg::MV_BITS+1)'(n_rec.cells);

    // control flops and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c]     <= '0;
                r_fill[c]    <= '0;
                r_ready[c]   <= 1'b0;
                r_off[c]     <= 1'b0;
                r_rec_vld[c] <= 1'b0;
            end
            r_fwd_vld <= 1'b0;
        end else begin
            if (rec_we) begin
                r_ptr[r_s1_idx]     <= n_ptr;
                r_fill[r_s1_idx]    <= n_fill;
                r_ready[r_s1_idx]   <= n_ready;
                r_off[r_s1_idx]     <= n_off;
                r_rec_vld[r_s1_idx] <= 1'b1;
            end
            r_fwd_vld <= rec_we;
        end
        r_fwd_idx <= r_s1_idx;
        r_fwd_rec <= n_rec;
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_req     <= r_s1_req;
        r_s2_idx     <= r_s1_idx;
        r_s2_chan    <= r_s1_chan;
        r_s2_inrange <= r_s1_inrange;
        r_s2_taken   <= s1_taken;
        r_s2_sum     <= n_rec.sum;
        r_s2_start   <= n_rec.start;
        r_s2_cells   <= n_rec.cells;
        r_s2_off     <= n_off;
        r_s2_trip    <= s1_trip;
        r_s2_rearm   <= s1_rearm;
    end

    // average by reciprocal multiply, exact over the sum range
    assign avg_prod = (SW+MW)'(r_s2_sum) * (SW+MW)'(RECIP);
    assign avg_div  = avg_prod[RSH +: bvm_pkg::MV_BITS];

    // average and low flag with hysteresis
    always_comb begin
        avg_cur = r_s2_inrange ? r_avg[r_s2_idx] : '0;
        low_cur = r_s2_inrange ? r_low[r_s2_idx] : 1'b0;
        n_avg   = r_s2_taken ? avg_div : avg_cur;
        n_low   = low_cur;
        if (r_s2_taken && (r_s2_req == bvm_pkg::REQ_SAMPLE)) begin
            if (!low_cur && (n_avg < r_s2_trip)) begin
                n_low = 1'b1;
            end else if (low_cur && ((bvm_pkg::MV_BITS+1)'(n_avg) >= r_s2_rearm)) begin
                n_low = 1'b0;
            end
        end
        s2_res = '0;
        s2_res.out_channel = r_s2_chan;
        if (r_s2_inrange) begin
            s2_res.avg_mv        = n_avg;
            s2_res.init_mv       = r_s2_start;
            s2_res.cell_count    = r_s2_cells;
            s2_res.low_flag      = n_low;
            s2_res.low_changed   = n_low != low_cur;
            s2_res.chan_disabled = r_s2_off;
            s2_res.sample_taken  = r_s2_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_avg[c] <= '0;
                r_low[c] <= 1'b0;
            end
        end else if (r_s2_vld && r_s2_inrange) begin
            r_avg[r_s2_idx] <= n_avg;
            r_low[r_s2_idx] <= n_low;
        end
    end

    // result queue
    assign q_pop      = o_res.valid && o_res.ready;
    assign o_res.valid = r_q_cnt != '0;
    assign o_res.data  = r_q[r_q_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (r_s2_vld) begin
                r_q_wp <= r_q_wp + QAW'(1);
            end
            if (q_pop) begin
                r_q_rp <= r_q_rp + QAW'(1);
            end
            r_q_cnt <= r_q_cnt + QCW'(r_s2_vld) - QCW'(q_pop);
        end
        if (r_s2_vld) begin
            r_q[r_q_wp] <= s2_res;
        end
    end

`ifndef SYNTHESIS
    // queue plus items in flight never exceed the queue
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (4'(r_q_cnt) + 4'(r_s1_vld) + 4'(r_s2_vld)) <= 4'(QD))
        else $error("result queue overrun");

    // window pointer stays inside the window
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (int'(r_s1_ptr) < WINDOW_DEPTH))
        else $error("window pointer out of range");

    // until the window is full the pointer follows the fill count
    a_fill_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && (r_s1_fill != D_FULL)) |-> (FW'(r_s1_ptr) == r_s1_fill))
        else $error("fill count and window pointer disagree");

    // a taken transaction always belongs to an existing channel
    a_taken_inrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_taken) |-> r_s2_inrange)
        else $error("taken transaction on missing channel");

    // low flag only changes on a taken sample
    a_low_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && s2_res.low_changed) |->
        (r_s2_taken && (r_s2_req == bvm_pkg::REQ_SAMPLE)))
        else $error("low flag changed outside a sample");
`endif

endmodule
